/* rtl/core/hjdc_pkg.sv */
// Shared types, constants and lookup tables for the Hijri / Julian day converter.
package hjdc_pkg;

    // Conversion direction carried in the input tuser bit
    localparam logic FUNC_TO_HIJRI = 1'b0;
    localparam logic FUNC_TO_JD    = 1'b1;

    localparam logic [3:0]  LAST_MONTH   = 4'd12;
    localparam logic [4:0]  LONG_MONTH   = 5'd30;
    localparam logic [4:0]  SHORT_MONTH  = 5'd29;

    // 1 Muharram 1 AH
    localparam logic [22:0] EPOCH_JD     = 23'd1948440;
    // jd - EPOCH_JD + 10632 - 1, the offset fed to the cycle divide
    localparam logic [22:0] CYC_BIAS     = 23'd1937809;
    // days in one 30-year cycle and floor(2^23 / 10631)
    localparam logic [22:0] CYC_DAYS     = 23'd10631;
    localparam logic [9:0]  CYC_RECIP    = 10'd789;
    localparam logic [13:0] CYC_L_BIAS   = 14'd355;
    // day index in the cycle where the second half-cycle formula starts
    localparam logic [13:0] LATE_START   = 14'd5670;
    localparam logic [13:0] L2_BIAS      = 14'd29;

    // floor(2^18 / 30) for (11y + 3) / 30
    localparam logic [13:0] DIV30_RECIP  = 14'd8738;
    localparam logic [5:0]  DIV30        = 6'd30;
    // remainder of (11y + 3) / 30 from which the year is a leap year
    localparam logic [5:0]  LEAP_REM_MIN = 6'd19;
    // Julian day of 1 Muharram of year y, less (11y + 3) / 30 + 354y
    localparam logic [22:0] YEAR_JD_BIAS = 23'd1948086;

    typedef logic [15:0][13:0] thr_early_tbl_t;
    typedef logic [31:0][13:0] thr_late_tbl_t;
    typedef logic [31:0][13:0] yr_ofs_tbl_t;
    typedef logic [15:0][8:0]  mon_tbl_t;

    // l >= entry k  <=>  floor(50 l / 17719) >= k
    function automatic thr_early_tbl_t build_thr_early();
        thr_early_tbl_t tbl;
        tbl = '0;
        for (int k = 1; k <= 15; k++) begin
            tbl[k] = 14'((17719 * k + 49) / 50);
        end
        return tbl;
    endfunction

    // l >= entry k  <=>  floor(43 l / 15238) >= k
    function automatic thr_late_tbl_t build_thr_late();
        thr_late_tbl_t tbl;
        tbl = '0;
        for (int k = 1; k <= 30; k++) begin
            tbl[k] = 14'((15238 * k + 42) / 43);
        end
        return tbl;
    endfunction

    // days of the cycle before year j of the cycle (offset form of the algorithm)
    function automatic yr_ofs_tbl_t build_yr_ofs();
        yr_ofs_tbl_t tbl;
        tbl = '0;
        for (int k = 0; k <= 30; k++) begin
            tbl[k] = 14'(((30 - k) / 15) * ((17719 * k) / 50)
                          + (k / 16) * ((15238 * k) / 43));
        end
        return tbl;
    endfunction

    // l2 >= entry k  <=>  floor(24 l2 / 709) >= k
    function automatic mon_tbl_t build_mon_start();
        mon_tbl_t tbl;
        tbl = '0;
        for (int k = 1; k <= 12; k++) begin
            tbl[k] = 9'((709 * k + 23) / 24);
        end
        return tbl;
    endfunction

    // floor(709 m / 24)
    function automatic mon_tbl_t build_mon_ofs();
        mon_tbl_t tbl;
        tbl = '0;
        for (int k = 0; k <= 12; k++) begin
            tbl[k] = 9'((709 * k) / 24);
        end
        return tbl;
    endfunction

    localparam thr_early_tbl_t YR_THR_EARLY = build_thr_early();
    localparam thr_late_tbl_t  YR_THR_LATE  = build_thr_late();
    localparam yr_ofs_tbl_t    YR_OFS       = build_yr_ofs();
    localparam mon_tbl_t       MON_START    = build_mon_start();
    localparam mon_tbl_t       MON_OFS      = build_mon_ofs();

    // One conversion as it moves down the pipeline
    typedef struct packed {
        logic        func;
        logic        ok;
        logic        chk_leap;   // day 30 of month 12: valid only in a leap year
        logic [22:0] jd;
        logic [14:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
    } hjdc_item_t;

    // Cycle split: cycle count n and day index l inside the cycle
    typedef struct packed {
        hjdc_item_t  item;
        logic [9:0]  n;
        logic [13:0] l;
    } hjdc_split_t;

    typedef struct packed {
        logic        valid_res;
        logic [22:0] julian_day_out;
        logic [14:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic        leap_year;
        logic [2:0]  day_of_week;
        logic [8:0]  day_of_year;
    } hjdc_res_t;

endpackage

/* rtl/core/hjdc_year_split.sv */
// Input check and 30-year cycle split of the day count (four stages).
module hjdc_year_split
    import hjdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  hjdc_item_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output hjdc_split_t out_data
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_in;
    logic [NSTG:0]   stg_en;

    hjdc_item_t  s1_item_reg, s1_item_next;
    logic [22:0] s1_a_reg, s1_a_next;
    hjdc_item_t  s2_item_reg;
    logic [22:0] s2_a_reg;
    logic [32:0] s2_prod_reg, s2_prod_next;
    hjdc_item_t  s3_item_reg;
    logic [9:0]  s3_qe_reg, s3_qe_next;
    logic [14:0] s3_rem_reg, s3_rem_next;
    hjdc_item_t  s4_item_reg;
    logic [9:0]  s4_n_reg, s4_n_next;
    logic [13:0] s4_l_reg, s4_l_next;

    logic [4:0]  len_max;
    logic [22:0] rem_full;
    logic [14:0] rem_adj;

    // a stage loads when empty or when its content moves on
    always_comb begin
        stg_en[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            stg_en[i] = !valid_reg[i] || stg_en[i + 1];
        end
    end

    assign valid_in  = {valid_reg[NSTG-2:0], in_valid};
    assign in_ready  = stg_en[0];
    assign out_valid = valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stg_en[i]) valid_reg[i] <= valid_in[i];
            end
        end
    end

    // stage 1: date range check, cycle offset
    always_comb begin
        s1_item_next = in_item;
        len_max = (in_item.m[0] || in_item.m == LAST_MONTH) ? LONG_MONTH : SHORT_MONTH;
        if (in_item.func == FUNC_TO_JD) begin
            s1_item_next.ok = (in_item.y != '0) && (in_item.m != '0)
                              && (in_item.m <= LAST_MONTH) && (in_item.d != '0)
                              && (in_item.d <= len_max);
            s1_item_next.chk_leap = (in_item.m == LAST_MONTH) && (in_item.d == LONG_MONTH);
        end else begin
            s1_item_next.ok = (in_item.jd >= EPOCH_JD);
            s1_item_next.chk_leap = 1'b0;
        end
        s1_a_next = in_item.jd - CYC_BIAS;
    end

    // stage 2: reciprocal multiply
    assign s2_prod_next = 33'(s1_a_reg) * 33'(CYC_RECIP);

    // stage 3: quotient estimate is exact or one short
    always_comb begin
        s3_qe_next  = s2_prod_reg[32:23];
        rem_full    = s2_a_reg - 23'(s3_qe_next) * CYC_DAYS;
        s3_rem_next = rem_full[14:0];
    end

    // stage 4: correction
    always_comb begin
        if (s3_rem_reg >= 15'(CYC_DAYS)) begin
            s4_n_next = s3_qe_reg + 10'd1;
            rem_adj   = s3_rem_reg - 15'(CYC_DAYS);
        end else begin
            s4_n_next = s3_qe_reg;
            rem_adj   = s3_rem_reg;
        end
        s4_l_next = rem_adj[13:0] + CYC_L_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            s1_item_reg <= s1_item_next;
            s1_a_reg    <= s1_a_next;
        end
        if (stg_en[1]) begin
            s2_item_reg <= s1_item_reg;
            s2_a_reg    <= s1_a_reg;
            s2_prod_reg <= s2_prod_next;
        end
        if (stg_en[2]) begin
            s3_item_reg <= s2_item_reg;
            s3_qe_reg   <= s3_qe_next;
            s3_rem_reg  <= s3_rem_next;
        end
        if (stg_en[3]) begin
            s4_item_reg <= s3_item_reg;
            s4_n_reg    <= s4_n_next;
            s4_l_reg    <= s4_l_next;
        end
    end

    assign out_data.item = s4_item_reg;
    assign out_data.n    = s4_n_reg;
    assign out_data.l    = s4_l_reg;

    // the corrected remainder always lands inside one cycle
    a_cycle_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[2] && stg_en[3] |=> (s4_l_reg >= CYC_L_BIAS) && (s4_l_reg <= 14'd10985))
        else $error("cycle day index out of range");

endmodule

/* rtl/core/hjdc_date_split.sv */
// Year of cycle, month and day from the cycle day index (four stages).
module hjdc_date_split
    import hjdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  hjdc_split_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output hjdc_item_t  out_item
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_in;
    logic [NSTG:0]   stg_en;

    hjdc_item_t  s1_item_reg;
    logic [9:0]  s1_n_reg;
    logic [13:0] s1_l_reg;
    logic [4:0]  s1_j_reg, s1_j_next;
    hjdc_item_t  s2_item_reg, s2_item_next;
    logic [8:0]  s2_l2_reg, s2_l2_next;
    hjdc_item_t  s3_item_reg, s3_item_next;
    logic [8:0]  s3_l2_reg;
    hjdc_item_t  s4_item_reg, s4_item_next;

    logic [14:0] hit_early;
    logic [29:0] hit_late;
    logic [11:0] hit_mon;
    logic [14:0] y_calc;
    logic [13:0] l2_full;
    logic [8:0]  d_full;

    always_comb begin
        stg_en[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            stg_en[i] = !valid_reg[i] || stg_en[i + 1];
        end
    end

    assign valid_in  = {valid_reg[NSTG-2:0], in_valid};
    assign in_ready  = stg_en[0];
    assign out_valid = valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stg_en[i]) valid_reg[i] <= valid_in[i];
            end
        end
    end

    // stage 1: year of cycle by threshold compare; the two half-cycles use
    // different slope constants
    always_comb begin
        for (int k = 1; k <= 15; k++) begin
            hit_early[k - 1] = (in_data.l >= YR_THR_EARLY[k]);
        end
        for (int k = 1; k <= 30; k++) begin
            hit_late[k - 1] = (in_data.l >= YR_THR_LATE[k]);
        end
        if (in_data.l >= LATE_START) begin
            s1_j_next = 5'($countones(hit_late));
        end else begin
            s1_j_next = 5'($countones(hit_early));
        end
    end

    // stage 2: absolute year, day index inside the year
    always_comb begin
        s2_item_next = s1_item_reg;
        y_calc  = 15'(s1_n_reg) * 15'd30 + 15'(s1_j_reg) - 15'd30;
        l2_full = s1_l_reg - YR_OFS[s1_j_reg] + L2_BIAS;
        s2_l2_next = l2_full[8:0];
        if (s1_item_reg.func == FUNC_TO_HIJRI) s2_item_next.y = y_calc;
    end

    // stage 3: month
    always_comb begin
        s3_item_next = s2_item_reg;
        for (int k = 1; k <= 12; k++) begin
            hit_mon[k - 1] = (s2_l2_reg >= MON_START[k]);
        end
        if (s2_item_reg.func == FUNC_TO_HIJRI) s3_item_next.m = 4'($countones(hit_mon));
    end

    // stage 4: day of month
    always_comb begin
        s4_item_next = s3_item_reg;
        d_full = s3_l2_reg - MON_OFS[s3_item_reg.m];
        if (s3_item_reg.func == FUNC_TO_HIJRI) s4_item_next.d = d_full[4:0];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            s1_item_reg <= in_data.item;
            s1_n_reg    <= in_data.n;
            s1_l_reg    <= in_data.l;
            s1_j_reg    <= s1_j_next;
        end
        if (stg_en[1]) begin
            s2_item_reg <= s2_item_next;
            s2_l2_reg   <= s2_l2_next;
        end
        if (stg_en[2]) begin
            s3_item_reg <= s3_item_next;
            s3_l2_reg   <= s2_l2_reg;
        end
        if (stg_en[3]) begin
            s4_item_reg <= s4_item_next;
        end
    end

    assign out_item = s4_item_reg;

    // a valid day count must decode to a real month and day
    a_decoded_date: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_item.ok && (out_item.func == FUNC_TO_HIJRI)
        |-> (out_item.m != '0) && (out_item.m <= LAST_MONTH)
            && (out_item.d != '0) && (out_item.d <= LONG_MONTH))
        else $error("decoded month or day out of range");

endmodule

/* rtl/core/hjdc_cal_back.sv */
// Leap flag, start-of-year day, Julian day, day of year and weekday (eight stages).
module hjdc_cal_back
    import hjdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  hjdc_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output hjdc_res_t  out_res
);

    localparam int NSTG = 8;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_in;
    logic [NSTG:0]   stg_en;

    hjdc_item_t  s1_item_reg;
    logic [17:0] s1_t_reg, s1_t_next;
    logic [8:0]  s1_doy_reg, s1_doy_next;
    hjdc_item_t  s2_item_reg;
    logic [17:0] s2_t_reg;
    logic [31:0] s2_prod_reg, s2_prod_next;
    logic [8:0]  s2_doy_reg;
    hjdc_item_t  s3_item_reg;
    logic [13:0] s3_qe_reg, s3_qe_next;
    logic [5:0]  s3_rem_reg, s3_rem_next;
    logic [8:0]  s3_doy_reg;
    hjdc_item_t  s4_item_reg, s4_item_next;
    logic [13:0] s4_q_reg, s4_q_next;
    logic        s4_leap_reg, s4_leap_next;
    logic [8:0]  s4_doy_reg;
    hjdc_item_t  s5_item_reg;
    logic [22:0] s5_base_reg, s5_base_next;
    logic        s5_leap_reg;
    logic [8:0]  s5_doy_reg;
    hjdc_item_t  s6_item_reg, s6_item_next;
    logic [8:0]  s6_doy_reg, s6_doy_next;
    logic        s6_leap_reg;
    hjdc_item_t  s7_item_reg;
    logic [8:0]  s7_doy_reg;
    logic        s7_leap_reg;
    logic [5:0]  s7_sum_reg, s7_sum_next;
    hjdc_res_t   res_reg, res_next;

    logic [3:0]  mm1;
    logic [17:0] rem_full;
    logic [5:0]  rem_adj;
    logic [22:0] doy_full;
    logic [23:0] jd_pad;
    logic [3:0]  wk_a;
    logic [3:0]  wk_b;
    logic [3:0]  wk_c;

    always_comb begin
        stg_en[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            stg_en[i] = !valid_reg[i] || stg_en[i + 1];
        end
    end

    assign valid_in  = {valid_reg[NSTG-2:0], in_valid};
    assign in_ready  = stg_en[0];
    assign out_valid = valid_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stg_en[i]) valid_reg[i] <= valid_in[i];
            end
        end
    end

    // stage 1: 11y + 3, day of year from month and day
    always_comb begin
        s1_t_next   = 18'(in_item.y) * 18'd11 + 18'd3;
        mm1         = in_item.m - 4'd1;
        s1_doy_next = 9'(mm1) * 9'd30 - 9'(mm1 >> 1) + 9'(in_item.d) - 9'd1;
    end

    // stage 2: reciprocal multiply for the divide by 30
    assign s2_prod_next = 32'(s1_t_reg) * 32'(DIV30_RECIP);

    // stage 3: estimate and remainder
    always_comb begin
        s3_qe_next  = s2_prod_reg[31:18];
        rem_full    = s2_t_reg - 18'(s3_qe_next) * 18'(DIV30);
        s3_rem_next = rem_full[5:0];
    end

    // stage 4: correction; leap year when (11y + 14) mod 30 < 11
    always_comb begin
        s4_item_next = s3_item_reg;
        if (s3_rem_reg >= DIV30) begin
            s4_q_next = s3_qe_reg + 14'd1;
            rem_adj   = s3_rem_reg - DIV30;
        end else begin
            s4_q_next = s3_qe_reg;
            rem_adj   = s3_rem_reg;
        end
        s4_leap_next = (rem_adj >= LEAP_REM_MIN);
        if (s3_item_reg.chk_leap && !s4_leap_next) s4_item_next.ok = 1'b0;
    end

    // stage 5: Julian day of 1 Muharram
    assign s5_base_next = 23'(s4_q_reg) + 23'(s4_item_reg.y) * 23'd354 + YEAR_JD_BIAS;

    // stage 6: Julian day or day of year, depending on direction
    always_comb begin
        s6_item_next = s5_item_reg;
        doy_full     = s5_item_reg.jd - s5_base_reg;
        if (s5_item_reg.func == FUNC_TO_JD) begin
            s6_item_next.jd = s5_base_reg + 23'(s5_doy_reg);
            s6_doy_next     = s5_doy_reg;
        end else begin
            s6_doy_next     = doy_full[8:0];
        end
    end

    // stage 7: octal digit sum, since 8 = 1 mod 7
    always_comb begin
        jd_pad      = {1'b0, s6_item_reg.jd};
        s7_sum_next = '0;
        for (int k = 0; k < 8; k++) begin
            s7_sum_next = s7_sum_next + 6'(jd_pad[3 * k +: 3]);
        end
    end

    // stage 8: finish mod 7, zero everything for an invalid date
    always_comb begin
        wk_a = 4'(s7_sum_reg[5:3]) + 4'(s7_sum_reg[2:0]);
        wk_b = 4'(wk_a[3]) + 4'(wk_a[2:0]);
        wk_c = (wk_b >= 4'd7) ? wk_b - 4'd7 : wk_b;
        res_next = '0;
        if (s7_item_reg.ok) begin
            res_next.valid_res      = 1'b1;
            res_next.julian_day_out = s7_item_reg.jd;
            res_next.year_out       = s7_item_reg.y;
            res_next.month_out      = s7_item_reg.m;
            res_next.day_out        = s7_item_reg.d;
            res_next.leap_year      = s7_leap_reg;
            res_next.day_of_week    = wk_c[2:0] + 3'd1;
            res_next.day_of_year    = s7_doy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            s1_item_reg <= in_item;
            s1_t_reg    <= s1_t_next;
            s1_doy_reg  <= s1_doy_next;
        end
        if (stg_en[1]) begin
            s2_item_reg <= s1_item_reg;
            s2_t_reg    <= s1_t_reg;
            s2_prod_reg <= s2_prod_next;
            s2_doy_reg  <= s1_doy_reg;
        end
        if (stg_en[2]) begin
            s3_item_reg <= s2_item_reg;
            s3_qe_reg   <= s3_qe_next;
            s3_rem_reg  <= s3_rem_next;
            s3_doy_reg  <= s2_doy_reg;
        end
        if (stg_en[3]) begin
            s4_item_reg <= s4_item_next;
            s4_q_reg    <= s4_q_next;
            s4_leap_reg <= s4_leap_next;
            s4_doy_reg  <= s3_doy_reg;
        end
        if (stg_en[4]) begin
            s5_item_reg <= s4_item_reg;
            s5_base_reg <= s5_base_next;
            s5_leap_reg <= s4_leap_reg;
            s5_doy_reg  <= s4_doy_reg;
        end
        if (stg_en[5]) begin
            s6_item_reg <= s6_item_next;
            s6_doy_reg  <= s6_doy_next;
            s6_leap_reg <= s5_leap_reg;
        end
        if (stg_en[6]) begin
            s7_item_reg <= s6_item_reg;
            s7_doy_reg  <= s6_doy_reg;
            s7_leap_reg <= s6_leap_reg;
            s7_sum_reg  <= s7_sum_next;
        end
        if (stg_en[7]) begin
            res_reg <= res_next;
        end
    end

    assign out_res = res_reg;

    a_div30_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[1] && stg_en[2] |=> (s3_rem_reg < 6'd60))
        else $error("divide by 30 estimate off by more than one");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_res.valid_res |-> (out_res == '0))
        else $error("invalid result carries nonzero fields");

    a_valid_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_res.valid_res
        |-> (out_res.day_of_week != '0) && (out_res.day_of_year <= 9'd354)
            && (out_res.year_out != '0))
        else $error("valid result with weekday, day of year or year out of range");

endmodule

/* rtl/core/hijri_julian_day_converter.sv */
// Top level of the tabular Islamic calendar / Julian day converter.
//
//  channel | dir | payload                                          | handshake
//  s_axis  | in  | tuser: func, tdata: day number or Hijri date     | tvalid/tready
//  m_axis  | out | tuser: valid_res, tdata: full converted date     | tvalid/tready
//
// One transaction per clock sustained in either direction unless m_axis stalls.
// There are four stages for the 30-year cycle divide, four for year/month/day,
// and eight for the leap flag, start of year, day of year and weekday.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on m_axis holds the last stage; earlier stages keep filling empty
// slots, so s_axis_tready drops only when every stage holds a transaction.
module hijri_julian_day_converter
    import hjdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // julian_day[22:0], year_in[36:23], month_in[40:37], day_in[45:41], zero[47:46]
    input  logic [47:0] s_axis_tdata,
    // func[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // julian_day_out[22:0], year_out[37:23], month_out[41:38], day_out[46:42],
    // leap_year[47], day_of_week[50:48], day_of_year[59:51], zero[63:60]
    output logic [63:0] m_axis_tdata,
    // valid_res[0]
    output logic        m_axis_tuser
);

    hjdc_item_t  in_item;
    hjdc_split_t ys_data;
    hjdc_item_t  ds_item;
    hjdc_res_t   res;
    logic        ys_valid, ys_ready;
    logic        ds_valid, ds_ready;

    always_comb begin
        in_item          = '0;
        in_item.func     = s_axis_tuser;
        in_item.jd       = s_axis_tdata[22:0];
        in_item.y        = {1'b0, s_axis_tdata[36:23]};
        in_item.m        = s_axis_tdata[40:37];
        in_item.d        = s_axis_tdata[45:41];
    end

    hjdc_year_split u_year_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (ys_valid),
        .out_ready (ys_ready),
        .out_data  (ys_data)
    );

    hjdc_date_split u_date_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ys_valid),
        .in_ready  (ys_ready),
        .in_data   (ys_data),
        .out_valid (ds_valid),
        .out_ready (ds_ready),
        .out_item  (ds_item)
    );

    hjdc_cal_back u_cal_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ds_valid),
        .in_ready  (ds_ready),
        .in_item   (ds_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tuser = res.valid_res;
    assign m_axis_tdata = {4'b0000, res.day_of_year, res.day_of_week, res.leap_year,
                           res.day_out, res.month_out, res.year_out, res.julian_day_out};

endmodule

/* test/hijri_julian_day_converter_tb.sv */
// Self-checking testbench for the Hijri / Julian day converter stream pipeline.
module hijri_julian_day_converter_tb;
    import hjdc_pkg::*;

    localparam int     CYCLE_LIMIT = 200000;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     RAND_ITEMS  = 1650;
    localparam longint EPOCH       = EPOCH_JD;

    typedef struct packed {
        logic        func;
        logic [22:0] jd;
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
    } date_req_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata   = '0;
    logic        s_axis_tuser   = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    date_req_t   date_reqs_q[$];
    hjdc_res_t   due_dates_q[$];
    date_req_t   cur_req;
    int          sent_cnt   = 0;
    int          rcvd_cnt   = 0;
    int          errors     = 0;
    int          cycle_cnt  = 0;
    int          stall_left = 0;
    bit          stall_done = 0;

    hijri_julian_day_converter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit hijri_leap(longint y);
        if (y < 1) return 1'b0;
        return ((11 * y + 14) % 30) < 11;
    endfunction

    function automatic longint hijri_jd(longint y, longint m, longint d);
        return (11 * y + 3) / 30 + 354 * y + 30 * m - (m - 1) / 2 + d + EPOCH - 385;
    endfunction

    function automatic int month_len(longint y, longint m);
        return (m == 12 && hijri_leap(y)) ? 30 : int'(m % 2) + 29;
    endfunction

    function automatic hjdc_res_t convert_date(date_req_t r);
        hjdc_res_t res;
        longint    l, n, j, yy, mm, dd, jd;
        bit        ok;
        res = '0;
        ok  = 1'b0;
        jd  = r.jd;
        yy  = 0;
        mm  = 0;
        dd  = 0;
        if (r.func == FUNC_TO_HIJRI) begin
            if (jd >= EPOCH) begin
                l  = jd - EPOCH + 10632;
                n  = (l - 1) / 10631;
                l  = l - 10631 * n + 354;
                j  = ((10985 - l) / 5316) * ((50 * l) / 17719)
                     + (l / 5670) * ((43 * l) / 15238);
                l  = l - ((30 - j) / 15) * ((17719 * j) / 50)
                     - (j / 16) * ((15238 * j) / 43) + 29;
                mm = (24 * l) / 709;
                dd = l - (709 * mm) / 24;
                yy = 30 * n + j - 30;
                ok = 1'b1;
            end
        end else begin
            yy = r.y;
            mm = r.m;
            dd = r.d;
            ok = (yy >= 1) && (mm >= 1) && (mm <= 12) && (dd >= 1);
            if (ok && dd > month_len(yy, mm)) ok = 1'b0;
            if (ok) jd = hijri_jd(yy, mm, dd);
        end
        if (ok) begin
            res.valid_res      = 1'b1;
            res.julian_day_out = 23'(jd);
            res.year_out       = 15'(yy);
            res.month_out      = 4'(mm);
            res.day_out        = 5'(dd);
            res.leap_year      = hijri_leap(yy);
            res.day_of_week    = 3'(jd % 7 + 1);
            res.day_of_year    = 9'(jd - hijri_jd(yy, 1, 1));
        end
        return res;
    endfunction

    task automatic push_date(logic func, logic [22:0] jd, logic [13:0] y,
                             logic [3:0] m, logic [4:0] d);
        date_req_t r;
        r.func = func;
        r.jd   = jd;
        r.y    = y;
        r.m    = m;
        r.d    = d;
        date_reqs_q.push_back(r);
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // source side: offers the next pending date, records the prediction on acceptance
    always @(posedge aclk) begin
        date_req_t nxt;
        bit        offer;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_dates_q.push_back(convert_date(cur_req));
                sent_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                offer = date_reqs_q.size() > 0 &&
                        ((sent_cnt >= 700 && sent_cnt < 1000) || $urandom_range(99) >= 27);
                if (offer) begin
                    nxt           = date_reqs_q.pop_front();
                    cur_req       = nxt;
                    s_axis_tdata  <= {2'b00, nxt.d, nxt.m, nxt.y, nxt.jd};
                    s_axis_tuser  <= nxt.func;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: compares each transaction against the oldest predicted date
    always @(posedge aclk) begin
        hjdc_res_t due;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_dates_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    due = due_dates_q.pop_front();
                    check_field("valid_res", due.valid_res, m_axis_tuser);
                    check_field("julian_day_out", due.julian_day_out, m_axis_tdata[22:0]);
                    check_field("year_out", due.year_out, m_axis_tdata[37:23]);
                    check_field("month_out", due.month_out, m_axis_tdata[41:38]);
                    check_field("day_out", due.day_out, m_axis_tdata[46:42]);
                    check_field("leap_year", due.leap_year, m_axis_tdata[47]);
                    check_field("day_of_week", due.day_of_week, m_axis_tdata[50:48]);
                    check_field("day_of_year", due.day_of_year, m_axis_tdata[59:51]);
                    check_field("tdata pad", 0, m_axis_tdata[63:60]);
                end
                rcvd_cnt++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!stall_done && rcvd_cnt == 300) begin
                // long back-pressure so the whole pipeline fills and s_axis_tready drops
                stall_done = 1'b1;
                stall_left = 400;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (rcvd_cnt >= 700 && rcvd_cnt < 1000) ||
                                 $urandom_range(99) >= 27;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int          i, sel, len;
        logic [13:0] y;
        logic [3:0]  m;
        date_req_t   r;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: epoch edges, field extremes, month-length and leap corners
        push_date(FUNC_TO_HIJRI, 23'd0, '0, '0, '0);
        push_date(FUNC_TO_HIJRI, 23'(EPOCH - 1), '1, '1, '1);
        push_date(FUNC_TO_HIJRI, 23'(EPOCH), '0, '0, '0);
        push_date(FUNC_TO_HIJRI, 23'(EPOCH + 354), '0, '0, '0);
        push_date(FUNC_TO_HIJRI, 23'(EPOCH + 709), '0, '0, '0);
        push_date(FUNC_TO_HIJRI, 23'd2460000, '0, '0, '0);
        push_date(FUNC_TO_HIJRI, 23'h7FFFFF, '1, '1, '1);
        push_date(FUNC_TO_JD, '1, 14'd1, 4'd1, 5'd1);
        push_date(FUNC_TO_JD, '0, 14'd0, 4'd1, 5'd1);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd0, 5'd1);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd13, 5'd1);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd15, 5'd1);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd1, 5'd0);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd1, 5'd30);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd1, 5'd31);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd2, 5'd29);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd2, 5'd30);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd12, 5'd29);
        push_date(FUNC_TO_JD, '0, 14'd1, 4'd12, 5'd30);
        push_date(FUNC_TO_JD, '0, 14'd2, 4'd12, 5'd30);
        push_date(FUNC_TO_JD, '0, 14'd16382, 4'd12, 5'd30);
        push_date(FUNC_TO_JD, '0, 14'd16383, 4'd12, 5'd30);
        push_date(FUNC_TO_JD, '0, 14'd16383, 4'd12, 5'd29);
        push_date(FUNC_TO_JD, '1, '1, '1, '1);

        // source pause: let every directed result drain before the random part
        do @(posedge aclk);
        while (date_reqs_q.size() != 0 || s_axis_tvalid || due_dates_q.size() != 0);

        for (i = 0; i < RAND_ITEMS; i++) begin
            r      = date_req_t'(47'({$urandom, $urandom}));
            r.func = 1'($urandom_range(1));
            sel    = $urandom_range(99);
            if (r.func == FUNC_TO_HIJRI) begin
                if (sel < 75)
                    r.jd = 23'($urandom_range(8388607, int'(EPOCH)));
                else if (sel < 88)
                    r.jd = 23'($urandom_range(int'(EPOCH) + 800, int'(EPOCH) - 20));
            end else if (sel < 85) begin
                y   = (sel < 40) ? 14'($urandom_range(60, 1)) : 14'($urandom_range(16383, 1));
                m   = 4'($urandom_range(12, 1));
                len = month_len(y, m);
                r.y = y;
                r.m = m;
                // well-formed most of the time, otherwise the last day of the month or one past it
                r.d = (sel < 70) ? 5'($urandom_range(len, 1)) : 5'(len + $urandom_range(1));
                if (sel >= 80) r.m = 4'd12;
            end
            date_reqs_q.push_back(r);
        end

        do @(posedge aclk);
        while (date_reqs_q.size() != 0 || s_axis_tvalid || due_dates_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (errors == 0 && due_dates_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
